// ===== rtl/lcdws_pkg.sv =====
// Shared types, codes and timing constants for the character LCD write sequencer.
package lcdws_pkg;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 32;
   localparam int HOLD_W     = 15;

   localparam logic [2:0] FUNC_CMD   = 3'd0;
   localparam logic [2:0] FUNC_DATA  = 3'd1;
   localparam logic [2:0] FUNC_GOTO  = 3'd2;
   localparam logic [2:0] FUNC_CLEAR = 3'd3;
   localparam logic [2:0] FUNC_INIT  = 3'd4;
   localparam logic [2:0] FUNC_GLYPH = 3'd5;

   localparam logic MODE_BYTE   = 1'b0;
   localparam logic MODE_NIBBLE = 1'b1;

   localparam logic [7:0] LCD_LINE0     = 8'h80;
   localparam logic [7:0] LCD_LINE1     = 8'hC0;
   localparam logic [7:0] LCD_CGRAM     = 8'h40;
   localparam logic [7:0] LCD_FUNC8     = 8'h38;
   localparam logic [7:0] LCD_FUNC4     = 8'h28;
   localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY     = 8'h06;
   localparam logic [7:0] LCD_CLEAR     = 8'h01;
   localparam logic [7:0] LCD_HOME      = 8'h02;
   localparam logic [7:0] NIBBLE_MASK   = 8'hF0;

   localparam logic [HOLD_W-1:0] HOLD_STROBE    = 15'd1;
   localparam logic [HOLD_W-1:0] HOLD_CMD8      = 15'd3000;
   localparam logic [HOLD_W-1:0] HOLD_DATA8     = 15'd1000;
   localparam logic [HOLD_W-1:0] HOLD_NIB_HI    = 15'd200;
   localparam logic [HOLD_W-1:0] HOLD_NIB_LO    = 15'd2000;
   localparam logic [HOLD_W-1:0] HOLD_NIB_EXTRA = 15'd4000;
   localparam logic [HOLD_W-1:0] HOLD_POWER     = 15'd20000;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_POWER = 4'b0100,
      ST_STEP  = 4'b1000
   } ctl_state_type;

   typedef struct packed {
      logic       capture;
      logic       emit;
      logic       power;
      logic       last;
      logic [3:0] xfer_idx;
      logic [1:0] step_idx;
   } ctl_cmd_type;

   typedef struct packed {
      logic [3:0] xfer_count;
      logic       power;
      logic       mode;
      logic       out_free;
   } ctl_status_type;

   // Power-up byte list, one entry per transfer.
   function automatic logic [7:0] init_byte(input logic mode, input logic [2:0] idx);
      logic [7:0] b;
      b = LCD_LINE0;
      case (idx)
         3'd0:    b = (mode == MODE_NIBBLE) ? LCD_HOME : LCD_FUNC8;
         3'd1:    b = (mode == MODE_NIBBLE) ? LCD_FUNC4 : LCD_DISP_ON;
         3'd2:    b = (mode == MODE_NIBBLE) ? LCD_DISP_ON : LCD_ENTRY;
         3'd3:    b = (mode == MODE_NIBBLE) ? LCD_ENTRY : LCD_CLEAR;
         3'd4:    b = (mode == MODE_NIBBLE) ? LCD_CLEAR : LCD_LINE0;
         default: b = LCD_LINE0;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/lcdws_datapath.sv =====
// Request capture, byte selection, pin-step formation and output register.
module lcdws_datapath
   import lcdws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  ctl_cmd_type           cmd,
   output ctl_status_type        status
);

   logic [2:0]  func_ff;
   logic [7:0]  value_ff;
   logic [7:0]  row_ff;
   logic [7:0]  column_ff;
   logic [7:0]  slot_ff;
   logic [63:0] glyph_ff;
   logic        mode_ff, mode_in;
   logic        valid_ff, valid_in;
   logic [7:0]  bus_ff, bus_in;
   logic        rs_ff, rs_in;
   logic        en_ff, en_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic        last_ff, last_in;

   logic [7:0]  xfer_byte;
   logic        xfer_rs;
   logic [3:0]  xfer_m1;
   logic        pos_ok;
   logic        add_extra;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid && csr_ready) begin
         mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BYTE;
         valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the request fields for the whole run.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff   <= req_tdata[2:0];
         value_ff  <= req_tdata[10:3];
         row_ff    <= req_tdata[18:11];
         column_ff <= req_tdata[26:19];
         slot_ff   <= req_tdata[34:27];
         glyph_ff  <= req_tdata[98:35];
      end
   end

   assign pos_ok = (column_ff < 8'd16) && ((row_ff == 8'd0) || (row_ff == 8'd1));

   always_comb begin
      status.power    = (func_ff == FUNC_INIT);
      status.mode     = mode_ff;
      status.out_free = !valid_ff || rsp_tready;
      case (func_ff)
         FUNC_CMD, FUNC_DATA: status.xfer_count = 4'd1;
         FUNC_GOTO:           status.xfer_count = pos_ok ? 4'd1 : 4'd0;
         FUNC_CLEAR:          status.xfer_count = 4'd2;
         FUNC_INIT:           status.xfer_count = 4'd5;
         FUNC_GLYPH:          status.xfer_count = (slot_ff < 8'd8) ? 4'd9 : 4'd0;
         default:             status.xfer_count = 4'd0;
      endcase
   end

   assign xfer_m1 = cmd.xfer_idx - 4'd1;

   always_comb begin
      xfer_byte = value_ff;
      xfer_rs   = 1'b0;
      case (func_ff)
         FUNC_CMD:   xfer_byte = value_ff;
         FUNC_DATA: begin
            xfer_byte = value_ff;
            xfer_rs   = 1'b1;
         end
         FUNC_GOTO:  xfer_byte = (row_ff[0] ? LCD_LINE1 : LCD_LINE0) | {4'h0, column_ff[3:0]};
         FUNC_CLEAR: xfer_byte = (cmd.xfer_idx == 4'd0) ? LCD_CLEAR : LCD_LINE0;
         FUNC_INIT:  xfer_byte = init_byte(mode_ff, cmd.xfer_idx[2:0]);
         FUNC_GLYPH: begin
            if (cmd.xfer_idx == 4'd0) begin
               xfer_byte = LCD_CGRAM | {2'b00, slot_ff[2:0], 3'b000};
            end else begin
               xfer_byte = glyph_ff[{xfer_m1[2:0], 3'b000} +: 8];
               xfer_rs   = 1'b1;
            end
         end
         default:    xfer_byte = value_ff;
      endcase
   end

   // Clear and init stretch the settle after the final 0x01 in nibble mode.
   assign add_extra = ((func_ff == FUNC_CLEAR) && (cmd.xfer_idx == 4'd0)) ||
                      ((func_ff == FUNC_INIT) && (cmd.xfer_idx == 4'd4));

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end

      bus_in  = bus_ff;
      rs_in   = rs_ff;
      en_in   = en_ff;
      hold_in = hold_ff;
      last_in = last_ff;
      if (cmd.emit) begin
         last_in = cmd.last;
         if (cmd.power) begin
            bus_in  = 8'h00;
            rs_in   = 1'b0;
            en_in   = 1'b0;
            hold_in = HOLD_POWER;
         end else begin
            rs_in = xfer_rs;
            en_in = !cmd.step_idx[0];
            if (mode_ff == MODE_NIBBLE) begin
               bus_in = cmd.step_idx[1] ? {xfer_byte[3:0], 4'h0} : (xfer_byte & NIBBLE_MASK);
            end else begin
               bus_in = xfer_byte;
            end
            if (!cmd.step_idx[0]) begin
               hold_in = HOLD_STROBE;
            end else if (mode_ff == MODE_BYTE) begin
               hold_in = xfer_rs ? HOLD_DATA8 : HOLD_CMD8;
            end else if (!cmd.step_idx[1]) begin
               hold_in = HOLD_NIB_HI;
            end else begin
               hold_in = add_extra ? HOLD_NIB_EXTRA : HOLD_NIB_LO;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      bus_ff  <= bus_in;
      rs_ff   <= rs_in;
      en_ff   <= en_in;
      hold_ff <= hold_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'b0, hold_ff, en_ff, 1'b0, rs_ff, bus_ff};

endmodule

// ===== rtl/lcdws_controller.sv =====
// Sequencer state machine: walks transfers and strobe steps of one request.
module lcdws_controller
   import lcdws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic [3:0]    xfer_ff, xfer_in;
   logic [1:0]    step_ff, step_in;
   logic          final_step;
   logic          last_xfer;

   assign req_tready = (state_ff == ST_IDLE);
   assign final_step = (status.mode == MODE_NIBBLE) ? (step_ff == 2'd3) : (step_ff == 2'd1);
   assign last_xfer  = (xfer_ff == (status.xfer_count - 4'd1));

   always_comb begin
      state_in     = state_ff;
      xfer_in      = xfer_ff;
      step_in      = step_ff;
      cmd.capture  = 1'b0;
      cmd.emit     = 1'b0;
      cmd.power    = 1'b0;
      cmd.last     = 1'b0;
      cmd.xfer_idx = xfer_ff;
      cmd.step_idx = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            xfer_in = 4'd0;
            step_in = 2'd0;
            if (status.xfer_count == 4'd0) begin
               state_in = ST_IDLE;
            end else if (status.power) begin
               state_in = ST_POWER;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_POWER: begin
            if (status.out_free) begin
               cmd.emit  = 1'b1;
               cmd.power = 1'b1;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = final_step && last_xfer;
               if (final_step) begin
                  step_in = 2'd0;
                  xfer_in = xfer_ff + 4'd1;
                  if (last_xfer) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  step_in = step_ff + 2'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         xfer_ff  <= 4'd0;
         step_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         xfer_ff  <= xfer_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("step emitted into a full output register");

   a_xfer_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (xfer_ff < status.xfer_count))
      else $error("transfer index ran past the request's transfer count");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("final step emitted but sequencer did not return to idle");

   a_power_first: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.power) |=> (xfer_ff == 4'd0 && step_ff == 2'd0))
      else $error("power-on step not followed by the first transfer");
`endif

endmodule

// ===== rtl/char_lcd_write_sequencer_top.sv =====
// Top level of the character LCD write sequencer.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | req_tdata: func, value, row, column, slot, glyph
//  rsp     | out | rsp_tvalid/rsp_tready   | rsp_tdata: bus, rs, rw, en, hold_us; rsp_tlast
//  csr     | in  | csr_valid/csr_ready     | csr_data: bus_mode
//
// A request passes a capture state (ST_IDLE) and a decode state (ST_START), then emits one
// pin step per cycle while the output register drains, up to 36 steps for a nine-transfer
// glyph in nibble mode. Requests that produce no steps return to idle from the decode state.
// Reset clears the sequencer and sets bus_mode to eight-bit transfers.
// A stalled rsp beat holds the sequencer; no new request is taken until the run ends.
module char_lcd_write_sequencer_top
   import lcdws_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func[2:0], value[10:3], row[18:11], column[26:19], slot[34:27], glyph[98:35]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // bus[7:0], reg_select[8], read_write[9], enable[10], hold_us[25:11]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   lcdws_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lcdws_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ===== tb/tb_char_lcd_write_sequencer_top.sv =====
// Self-checking testbench for the character LCD write sequencer.
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer_top
   import lcdws_pkg::*;
();

   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   localparam logic [HOLD_W-1:0] T_STROBE    = 15'd1;
   localparam logic [HOLD_W-1:0] T_CMD8      = 15'd3000;
   localparam logic [HOLD_W-1:0] T_DATA8     = 15'd1000;
   localparam logic [HOLD_W-1:0] T_NIB_HI    = 15'd200;
   localparam logic [HOLD_W-1:0] T_NIB_LO    = 15'd2000;
   localparam logic [HOLD_W-1:0] T_NIB_EXTRA = 15'd2000;
   localparam logic [HOLD_W-1:0] T_POWER     = 15'd20000;

   localparam int LCD_COLS     = 16;
   localparam int GLYPH_SLOTS  = 8;
   localparam int MAX_STEPS    = 54;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES = 64;
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PRINT_LIMIT  = 40;

   // last field in the lowest bits
   typedef struct packed {
      logic [63:0] glyph;
      logic [7:0]  slot;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [7:0]  value;
      logic [2:0]  func;
   } lcd_req_type;

   typedef struct packed {
      logic [7:0]        bus;
      logic              rs;
      logic              rw;
      logic              en;
      logic [HOLD_W-1:0] hold;
      logic              last;
   } lcd_step_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_data = 1'b0;

   lcd_req_type    pending [$];
   lcd_step_type   expected_steps [$];
   lcd_step_type   run_buf [0:MAX_STEPS-1];
   int          run_len;
   logic        mode_shadow = MODE_BYTE;
   int unsigned req_idle_max = 0;
   int unsigned rsp_idle_max = 0;
   int unsigned send_gap = 0;
   int unsigned wait_left = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_served = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   char_lcd_write_sequencer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic void put_step(input logic [7:0] b, input logic rs, input logic en,
                                    input logic [HOLD_W-1:0] hold);
      run_buf[run_len] = '{bus: b, rs: rs, rw: 1'b0, en: en, hold: hold, last: 1'b0};
      run_len++;
   endfunction

   function automatic void send_byte(input logic [7:0] b, input logic rs, input logic mode);
      if (mode == MODE_BYTE) begin
         put_step(b, rs, 1'b1, T_STROBE);
         put_step(b, rs, 1'b0, rs ? T_DATA8 : T_CMD8);
      end else begin
         put_step(b & NIBBLE_MASK, rs, 1'b1, T_STROBE);
         put_step(b & NIBBLE_MASK, rs, 1'b0, T_NIB_HI);
         put_step({b[3:0], 4'h0}, rs, 1'b1, T_STROBE);
         put_step({b[3:0], 4'h0}, rs, 1'b0, T_NIB_LO);
      end
   endfunction

   function automatic void predict_steps(input lcd_req_type r, input logic mode);
      int i;
      run_len = 0;
      case (r.func)
         FUNC_CMD:  send_byte(r.value, 1'b0, mode);
         FUNC_DATA: send_byte(r.value, 1'b1, mode);
         FUNC_GOTO: begin
            if (r.column < 8'(LCD_COLS)) begin
               if (r.row == 8'd0)
                  send_byte(LCD_LINE0 | r.column, 1'b0, mode);
               else if (r.row == 8'd1)
                  send_byte(LCD_LINE1 | r.column, 1'b0, mode);
            end
         end
         FUNC_CLEAR: begin
            send_byte(LCD_CLEAR, 1'b0, mode);
            if (mode == MODE_NIBBLE)
               run_buf[run_len-1].hold = run_buf[run_len-1].hold + T_NIB_EXTRA;
            send_byte(LCD_LINE0, 1'b0, mode);
         end
         FUNC_INIT: begin
            put_step(8'h00, 1'b0, 1'b0, T_POWER);
            if (mode == MODE_BYTE) begin
               send_byte(LCD_FUNC8, 1'b0, mode);
               send_byte(LCD_DISP_ON, 1'b0, mode);
               send_byte(LCD_ENTRY, 1'b0, mode);
               send_byte(LCD_CLEAR, 1'b0, mode);
               send_byte(LCD_LINE0, 1'b0, mode);
            end else begin
               send_byte(LCD_HOME, 1'b0, mode);
               send_byte(LCD_FUNC4, 1'b0, mode);
               send_byte(LCD_DISP_ON, 1'b0, mode);
               send_byte(LCD_ENTRY, 1'b0, mode);
               send_byte(LCD_CLEAR, 1'b0, mode);
               run_buf[run_len-1].hold = run_buf[run_len-1].hold + T_NIB_EXTRA;
            end
         end
         FUNC_GLYPH: begin
            if (r.slot < 8'(GLYPH_SLOTS)) begin
               send_byte(LCD_CGRAM + {r.slot[4:0], 3'b000}, 1'b0, mode);
               for (i = 0; i < 8; i++)
                  send_byte(r.glyph[8*i +: 8], 1'b1, mode);
            end
         end
         default: ;
      endcase
      if (run_len > 0)
         run_buf[run_len-1].last = 1'b1;
      for (i = 0; i < run_len; i++)
         expected_steps.push_back(run_buf[i]);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      if (mismatches < PRINT_LIMIT)
         $display("mismatch %0s: expected %0h got %0h at %0t", what, want, got, $time);
      mismatches++;
   endtask

   // ---------------------------------------------------------------- request driver

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending.size() != 0) begin
            req_tdata <= {5'b0, pending.pop_front()};
            req_tvalid <= 1'b1;
            send_gap = $urandom_range(0, req_idle_max);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      lcd_req_type  seen;
      lcd_step_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         wait_left = 0;
      end else begin
         // predict first: a beat accepted now is always older than any step it causes
         if (req_tvalid && req_tready) begin
            seen = req_tdata[98:0];
            predict_steps(seen, mode_shadow);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("step with nothing expected", 0, rsp_tdata);
            end else begin
               want = expected_steps.pop_front();
               if (rsp_tdata[7:0] !== want.bus)
                  report_mismatch("bus", 32'(want.bus), 32'(rsp_tdata[7:0]));
               if (rsp_tdata[8] !== want.rs)
                  report_mismatch("reg_select", 32'(want.rs), 32'(rsp_tdata[8]));
               if (rsp_tdata[9] !== want.rw)
                  report_mismatch("read_write", 32'(want.rw), 32'(rsp_tdata[9]));
               if (rsp_tdata[10] !== want.en)
                  report_mismatch("enable", 32'(want.en), 32'(rsp_tdata[10]));
               if (rsp_tdata[25:11] !== want.hold)
                  report_mismatch("hold_us", 32'(want.hold), 32'(rsp_tdata[25:11]));
               if (rsp_tlast !== want.last)
                  report_mismatch("last", 32'(want.last), 32'(rsp_tlast));
            end
            wait_left = $urandom_range(0, rsp_idle_max);
         end else if (wait_left > 0) begin
            wait_left--;
         end
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            wait_left = LONG_HOLD;
         end
         rsp_tready <= (wait_left == 0);
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic lcd_req_type make_req(input logic [2:0] f, input logic [7:0] v,
                                            input logic [7:0] row, input logic [7:0] col,
                                            input logic [7:0] slot, input logic [63:0] g);
      return '{func: f, value: v, row: row, column: col, slot: slot, glyph: g};
   endfunction

   // wait until every offered beat is taken and every step has come back
   task automatic settle;
      do @(negedge clock);
      while (pending.size() != 0 || req_tvalid || expected_steps.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      @(posedge clock);
      csr_data <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      mode_shadow = mode;
      @(negedge clock);
   endtask

   task automatic queue_random(input int count);
      lcd_req_type r;
      int          made;
      int unsigned pick;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         r.value  = 8'($urandom);
         r.row    = 8'($urandom_range(0, 1));
         r.column = 8'($urandom_range(0, LCD_COLS - 1));
         r.slot   = 8'($urandom_range(0, GLYPH_SLOTS - 1));
         r.glyph  = {$urandom, $urandom};
         if (pick < 20)
            r.func = FUNC_CMD;
         else if (pick < 40)
            r.func = FUNC_DATA;
         else if (pick < 58)
            r.func = FUNC_GOTO;
         else if (pick < 65)
            r.func = FUNC_CLEAR;
         else if (pick < 71)
            r.func = FUNC_INIT;
         else if (pick < 87)
            r.func = FUNC_GLYPH;
         else if (pick < 92) begin
            // arbitrary position, mostly off the screen
            r.func = FUNC_GOTO;
            r.row = 8'($urandom);
            r.column = 8'($urandom);
         end else if (pick < 96) begin
            r.func = FUNC_GLYPH;
            r.slot = 8'($urandom);
         end else begin
            r.func = pick[0] ? FUNC_SPARE_A : FUNC_SPARE_B;
         end
         pending.push_back(r);
         made++;
      end
   endtask

   task automatic run_phase(input logic mode, input int count, input int unsigned req_idle,
                            input int unsigned rsp_idle, input bit long_hold);
      settle;
      write_mode(mode);
      req_idle_max = req_idle;
      rsp_idle_max = rsp_idle;
      if (long_hold)
         hold_asked++;
      queue_random(count);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // eight-bit transfers, straight out of reset
      req_idle_max = 4;
      rsp_idle_max = 4;
      pending.push_back(make_req(FUNC_CMD, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_CMD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, '1));
      pending.push_back(make_req(FUNC_DATA, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'd0, 8'd0, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'd1, 8'd15, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'd2, 8'd0, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'd0, 8'd16, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'hFF, 8'hFF, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GLYPH, 8'h00, 8'h00, 8'h00, 8'd0, '1));
      pending.push_back(make_req(FUNC_GLYPH, 8'h00, 8'h00, 8'h00, 8'd7,
                                 64'h0123_4567_89AB_CDEF));
      pending.push_back(make_req(FUNC_GLYPH, 8'h00, 8'h00, 8'h00, 8'd8, '1));
      pending.push_back(make_req(FUNC_GLYPH, 8'h00, 8'h00, 8'h00, 8'hFF, '1));
      pending.push_back(make_req(FUNC_SPARE_A, 8'hFF, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_SPARE_B, 8'hFF, 8'h00, 8'h00, 8'h00, 64'h0));

      // nibble transfers
      settle;
      write_mode(MODE_NIBBLE);
      pending.push_back(make_req(FUNC_CMD, 8'hA5, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_DATA, 8'h5A, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GOTO, 8'h00, 8'd1, 8'd7, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_INIT, 8'h00, 8'h00, 8'h00, 8'h00, 64'h0));
      pending.push_back(make_req(FUNC_GLYPH, 8'h00, 8'h00, 8'h00, 8'd3,
                                 64'hFEDC_BA98_7654_3210));

      run_phase(MODE_BYTE, 70, 12, 12, 1'b0);
      run_phase(MODE_NIBBLE, 50, 0, 0, 1'b0);
      // keep offering while the result side sits still
      run_phase(MODE_NIBBLE, 50, 0, 12, 1'b1);
      run_phase(MODE_BYTE, 60, 12, 0, 1'b0);
      run_phase(MODE_NIBBLE, 60, 12, 12, 1'b0);
      run_phase(MODE_BYTE, 55, 3, 3, 1'b1);

      settle;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lcdws_pkg.sv
rtl/lcdws_datapath.sv
rtl/lcdws_controller.sv
rtl/char_lcd_write_sequencer_top.sv
tb/tb_char_lcd_write_sequencer_top.sv
